// ===== hdl/sms_pkg.sv =====
// Shared types and constants for the sample mean and standard deviation block.
`default_nettype none

package sms_pkg;

  localparam int SAMPLE_W = 16;
  localparam int RESULT_W = 24;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_SINGLE  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd2;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } op_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } arith_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/sms_in_if.sv =====
// Sample channel: one sample word with its end-of-set mark.
`default_nettype none

interface sms_in_if;
  import sms_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                last;

  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

`default_nettype wire

// ===== hdl/sms_out_if.sv =====
// Result channel: mean, standard deviation and status of one closed set.
`default_nettype none

interface sms_out_if;
  import sms_pkg::*;

  logic                valid;
  logic                ready;
  logic [RESULT_W-1:0] mean_q8;
  logic [RESULT_W-1:0] std_q8;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output mean_q8, output std_q8, output status, input ready);
  modport sink (input valid, input mean_q8, input std_q8, input status, output ready);
endinterface

`default_nettype wire

// ===== hdl/sms_arith.sv =====
// Shared bit-serial unit: shift-add multiply, restoring divide and square root.
`default_nettype none

module sms_arith #(
  parameter int W = 70
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire sms_pkg::arith_ctrl_t ctrl,
  input  wire [$clog2(W+1)-1:0]    steps,
  input  wire [W-1:0]              a,
  input  wire [W-1:0]              b,
  output logic                     done,
  output logic [W-1:0]             result
);
  import sms_pkg::*;

  localparam int SW = $clog2(W+1);

  logic          busy;
  op_t           op_r;
  logic [SW-1:0] cnt;
  logic [W-1:0]  x;
  logic [W-1:0]  y;
  logic [W-1:0]  acc;

  logic [W-1:0]  t_div;
  logic [W-1:0]  t_sqrt;
  logic [W-1:0]  trial;
  logic [W-1:0]  lhs;
  logic [W-1:0]  rhs;
  logic          sub;
  logic [W:0]    sum;
  logic [W-1:0]  diff;
  logic          ge;

  // The dividend and the radicand enter at the top of x and leave it one bit
  // or one bit pair per step; the partial remainder builds up in acc.
  assign t_div  = {acc[W-2:0], x[W-1]};
  assign t_sqrt = {acc[W-3:0], x[W-1:W-2]};
  assign trial  = {y[W-3:0], 2'b01};

  always_comb begin
    case (op_r)
      OP_MUL: begin
        lhs = acc;
        rhs = x;
        sub = 1'b0;
      end
      OP_DIV: begin
        lhs = t_div;
        rhs = y;
        sub = 1'b1;
      end
      OP_SQRT: begin
        lhs = t_sqrt;
        rhs = trial;
        sub = 1'b1;
      end
      default: begin
        lhs = acc;
        rhs = x;
        sub = 1'b0;
      end
    endcase
  end

  assign sum  = {1'b0, lhs} + {1'b0, rhs ^ {W{sub}}} + (W+1)'(sub);
  assign diff = sum[W-1:0];
  assign ge   = sum[W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        op_r <= ctrl.op;
        x    <= a;
        y    <= (ctrl.op == OP_SQRT) ? '0 : b;
        acc  <= '0;
        cnt  <= steps;
        busy <= 1'b1;
      end else if (busy) begin
        case (op_r)
          OP_MUL: begin
            if (y[0]) begin
              acc <= diff;
            end
            x <= {x[W-2:0], 1'b0};
            y <= {1'b0, y[W-1:1]};
          end
          OP_DIV: begin
            acc <= ge ? diff : t_div;
            x   <= {x[W-2:0], ge};
          end
          OP_SQRT: begin
            acc <= ge ? diff : t_sqrt;
            y   <= {y[W-2:0], ge};
            x   <= {x[W-3:0], 2'b00};
          end
          default: begin
            acc <= acc;
          end
        endcase
        cnt <= cnt - SW'(1);
        if (cnt == SW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    case (op_r)
      OP_MUL:  result = acc;
      OP_DIV:  result = x;
      OP_SQRT: result = y;
      default: result = acc;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/sample_mean_and_std.sv =====
// Sample mean and sample standard deviation, Q.8, of sets of unsigned samples.
// Samples are taken one per cycle while a set accumulates.
// After the last word of a set, one shared bit-serial unit runs six steps in turn, or
// only the mean divide for a set of one sample. No sample is taken meanwhile.
// Synchronous reset clears the accumulators, the sequencer and the result valid flag.
`default_nettype none

module sample_mean_and_std #(
  parameter int MAX_SAMPLES = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input wire        clk,
  input wire        rst,
  sms_in_if.sink    samples,
  sms_out_if.source results
);
  import sms_pkg::*;

  localparam int XW    = (SAMPLE_BITS >= SAMPLE_W) ? SAMPLE_W : SAMPLE_BITS;
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = XW + $clog2(MAX_SAMPLES);
  localparam int SQ_W  = 2 * XW + $clog2(MAX_SAMPLES);
  localparam int D_W   = CNT_W + SQ_W;
  localparam int M_W   = 2 * CNT_W;
  localparam int W     = ((D_W + 17) / 2) * 2;
  localparam int SW    = $clog2(W + 1);

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_DIV_MEAN,
    ST_MUL_NQ,
    ST_MUL_SS,
    ST_MUL_M,
    ST_DIV_STD,
    ST_SQRT,
    ST_OUT
  } state_t;

  state_t state;
  logic   issued;

  logic [CNT_W-1:0] cnt;
  logic [SUM_W-1:0] sum;
  logic [SQ_W-1:0]  sq;
  logic             ovf;

  logic [CNT_W-1:0] n_s;
  logic [SUM_W-1:0] s_s;
  logic [SQ_W-1:0]  q_s;
  logic             ovf_s;

  logic [W-1:0]     nq;
  logic [D_W-1:0]   d;
  logic [M_W-1:0]   m;

  logic [RESULT_W-1:0] mean_r;
  logic [RESULT_W-1:0] std_r;
  logic [STATUS_W-1:0] status_r;
  logic                out_valid;
  logic [RESULT_W-1:0] out_mean;
  logic [RESULT_W-1:0] out_std;
  logic [STATUS_W-1:0] out_status;

  logic [XW-1:0]    x;
  logic [2*XW-1:0]  x_sq;
  logic             keep;
  logic             accept;
  logic [CNT_W-1:0] cnt_next;
  logic [SUM_W-1:0] sum_next;
  logic [SQ_W-1:0]  sq_next;
  logic             ovf_next;

  arith_ctrl_t  ctrl;
  logic [SW-1:0] steps;
  logic [W-1:0]  opa;
  logic [W-1:0]  opb;
  logic          unit_done;
  logic [W-1:0]  unit_res;
  logic          out_free;

  assign x        = samples.sample[XW-1:0];
  assign x_sq     = x * x;
  assign keep     = cnt < CNT_W'(MAX_SAMPLES);
  assign accept   = samples.valid && samples.ready;
  assign cnt_next = keep ? cnt + CNT_W'(1) : cnt;
  assign sum_next = keep ? sum + SUM_W'(x) : sum;
  assign sq_next  = keep ? sq + SQ_W'(x_sq) : sq;
  assign ovf_next = ovf | ~keep;

  assign samples.ready   = (state == ST_ACCUM);
  assign results.valid   = out_valid;
  assign results.mean_q8 = out_mean;
  assign results.std_q8  = out_std;
  assign results.status  = out_status;

  assign out_free = !out_valid || results.ready;

  // Operands for the shared unit. The mean dividend sits at the top of the word.
  always_comb begin
    ctrl.start = 1'b0;
    ctrl.op    = OP_MUL;
    steps      = SW'(1);
    opa        = '0;
    opb        = '0;
    case (state)
      ST_DIV_MEAN: begin
        ctrl.start = !issued;
        ctrl.op    = OP_DIV;
        steps      = SW'(SUM_W + 8);
        opa        = W'(s_s) << (W - SUM_W);
        opb        = W'(n_s);
      end
      ST_MUL_NQ: begin
        ctrl.start = !issued;
        ctrl.op    = OP_MUL;
        steps      = SW'(CNT_W);
        opa        = W'(q_s);
        opb        = W'(n_s);
      end
      ST_MUL_SS: begin
        ctrl.start = !issued;
        ctrl.op    = OP_MUL;
        steps      = SW'(SUM_W);
        opa        = W'(s_s);
        opb        = W'(s_s);
      end
      ST_MUL_M: begin
        ctrl.start = !issued;
        ctrl.op    = OP_MUL;
        steps      = SW'(CNT_W);
        opa        = W'(n_s);
        opb        = W'(n_s - CNT_W'(1));
      end
      ST_DIV_STD: begin
        ctrl.start = !issued;
        ctrl.op    = OP_DIV;
        steps      = SW'(W);
        opa        = W'({d, 16'h0000});
        opb        = W'(m);
      end
      ST_SQRT: begin
        ctrl.start = !issued;
        ctrl.op    = OP_SQRT;
        steps      = SW'(W / 2);
        opa        = nq;
        opb        = '0;
      end
      default: begin
        ctrl.start = 1'b0;
      end
    endcase
  end

  sms_arith #(
    .W (W)
  ) u_arith (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .steps  (steps),
    .a      (opa),
    .b      (opb),
    .done   (unit_done),
    .result (unit_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACCUM;
      issued    <= 1'b0;
      cnt       <= '0;
      sum       <= '0;
      sq        <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // In ST_OUT the result register is reloaded below whenever it is taken.
      if (results.valid && results.ready && state != ST_OUT) begin
        out_valid <= 1'b0;
      end
      if (ctrl.start) begin
        issued <= 1'b1;
      end
      case (state)
        ST_ACCUM: begin
          if (accept) begin
            if (samples.last) begin
              n_s   <= cnt_next;
              s_s   <= sum_next;
              q_s   <= sq_next;
              ovf_s <= ovf_next;
              cnt   <= '0;
              sum   <= '0;
              sq    <= '0;
              ovf   <= 1'b0;
              state <= ST_DIV_MEAN;
            end else begin
              cnt <= cnt_next;
              sum <= sum_next;
              sq  <= sq_next;
              ovf <= ovf_next;
            end
          end
        end
        ST_DIV_MEAN: begin
          if (unit_done) begin
            issued <= 1'b0;
            mean_r <= RESULT_W'(unit_res);
            if (n_s < CNT_W'(2)) begin
              std_r    <= '0;
              status_r <= STATUS_SINGLE;
              state    <= ST_OUT;
            end else begin
              status_r <= ovf_s ? STATUS_DROPPED : STATUS_OK;
              state    <= ST_MUL_NQ;
            end
          end
        end
        ST_MUL_NQ: begin
          if (unit_done) begin
            issued <= 1'b0;
            nq     <= unit_res;
            state  <= ST_MUL_SS;
          end
        end
        ST_MUL_SS: begin
          if (unit_done) begin
            issued <= 1'b0;
            d      <= D_W'(nq - unit_res);
            state  <= ST_MUL_M;
          end
        end
        ST_MUL_M: begin
          if (unit_done) begin
            issued <= 1'b0;
            m      <= M_W'(unit_res);
            state  <= ST_DIV_STD;
          end
        end
        ST_DIV_STD: begin
          // The scaled variance is parked in nq until the root is taken.
          if (unit_done) begin
            issued <= 1'b0;
            nq     <= unit_res;
            state  <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (unit_done) begin
            issued <= 1'b0;
            std_r  <= RESULT_W'(unit_res);
            state  <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_mean   <= mean_r;
            out_std    <= std_r;
            out_status <= status_r;
            state      <= ST_ACCUM;
          end
        end
        default: begin
          state <= ST_ACCUM;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sms_checker.sv =====
// Port-level checks for the sample mean and standard deviation block, with its bind.
`default_nettype none

module sms_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          in_valid,
  input wire                          in_ready,
  input wire                          in_last,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire [sms_pkg::RESULT_W-1:0]  mean_q8,
  input wire [sms_pkg::RESULT_W-1:0]  std_q8,
  input wire [sms_pkg::STATUS_W-1:0]  status
);
  import sms_pkg::*;

  // A result word waiting to be taken keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mean_q8) && $stable(std_q8)
      && $stable(status))
    else $error("result word changed while stalled");

  // Closing a set starts the computation, so no sample is taken next cycle.
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("sample taken right after the end of a set");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == STATUS_OK || status == STATUS_SINGLE
      || status == STATUS_DROPPED))
    else $error("undefined status code");

  a_single_std: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_SINGLE |-> std_q8 == '0)
    else $error("nonzero deviation for a single sample");

endmodule

bind sample_mean_and_std sms_checker u_sms_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .in_last   (samples.last),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .mean_q8   (results.mean_q8),
  .std_q8    (results.std_q8),
  .status    (results.status)
);

`default_nettype wire
